// ----- rtl/core/cepm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cepm_pkg;

    // Field widths
    localparam int COUNT_W    = 48;
    localparam int COEFF_W    = 32;
    localparam int TIME_W     = 63;
    localparam int CPU_W      = 62;
    localparam int ENERGY_W   = 44;
    localparam int POWER_W    = 63;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam int NUM_COEFF   = 8;
    localparam int GROUP_LANES = 4;

    // Defaults for top-level parameters
    localparam int COEFF_SCALE_DEF = 1000;
    localparam int EFF_EVENTS_DEF  = 4;
    localparam int PERF_EVENTS_DEF = 4;

    // Lane arithmetic: count split into two halves, each times the weight
    localparam int HALF_W = COUNT_W / 2;
    localparam int PART_W = HALF_W + 1 + COEFF_W;
    localparam int PROD_W = COUNT_W + COEFF_W + 1;
    localparam int I64_W  = 64;
    localparam int SUM_W  = I64_W + 2;

    // Energy and power scaling
    localparam int ACC_W = 63;
    localparam int MW_W  = 20;
    localparam logic [MW_W-1:0]  UJ_TO_MW   = 20'd1000000;
    localparam logic [ACC_W-1:0] ENERGY_MAX = 63'd9223372036854;

    // Pipeline layout
    localparam int LANE_STG   = 2;
    localparam int MERGE_STG  = 3;
    localparam int CDIV_STEP  = 8;
    localparam int CDIV_STG   = (ACC_W + CDIV_STEP - 1) / CDIV_STEP;
    localparam int CDIV_PAD   = CDIV_STG * CDIV_STEP;
    localparam int DIV_W      = 63;
    localparam int DIV_STG    = DIV_W;
    localparam int ST_MERGE0  = LANE_STG;
    localparam int ST_CDIV0   = ST_MERGE0 + MERGE_STG;
    localparam int ST_SCALE   = ST_CDIV0 + CDIV_STG;
    localparam int ST_DIV0    = ST_SCALE + 1;
    localparam int ST_OUT     = ST_DIV0 + DIV_STG;
    localparam int NUM_STG    = ST_OUT + 1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_RUN   = 2'd1,
        ST_BAD_TIME = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEFF_EFF_A  = 4'd0,
        REG_COEFF_EFF_B  = 4'd1,
        REG_COEFF_EFF_C  = 4'd2,
        REG_COEFF_EFF_D  = 4'd3,
        REG_COEFF_PERF_A = 4'd4,
        REG_COEFF_PERF_B = 4'd5,
        REG_COEFF_PERF_C = 4'd6,
        REG_COEFF_PERF_D = 4'd7
    } cfg_reg_e;

    typedef struct packed {
        logic [COUNT_W-1:0] eff_count_a;
        logic [COUNT_W-1:0] eff_count_b;
        logic [COUNT_W-1:0] eff_count_c;
        logic [COUNT_W-1:0] eff_count_d;
        logic [COUNT_W-1:0] perf_count_a;
        logic [COUNT_W-1:0] perf_count_b;
        logic [COUNT_W-1:0] perf_count_c;
        logic [COUNT_W-1:0] perf_count_d;
        logic [TIME_W-1:0]  start_time_ns;
        logic [TIME_W-1:0]  now_time_ns;
        logic [CPU_W-1:0]   eff_cpu_ns;
        logic [CPU_W-1:0]   perf_cpu_ns;
    } in_item_t;

    typedef struct packed {
        status_e              status;
        logic [ENERGY_W-1:0]  est_energy;
        logic [POWER_W-1:0]   power_wall_mw;
        logic [POWER_W-1:0]   power_oncpu_mw;
    } out_item_t;

    // One lane's weighted product, two's complement, plus range flag
    typedef struct packed {
        logic [I64_W-1:0] prod;
        logic             ovf;
    } lane_res_t;

    function automatic logic fits_i64_prod(input logic [PROD_W-1:0] x);
        return x[PROD_W-1:I64_W-1] == {(PROD_W-I64_W+1){x[I64_W-1]}};
    endfunction

    function automatic logic fits_i64_sum(input logic [SUM_W-1:0] x);
        return x[SUM_W-1:I64_W-1] == {(SUM_W-I64_W+1){x[I64_W-1]}};
    endfunction

    function automatic logic [SUM_W-1:0] sext_sum(input logic [I64_W-1:0] x);
        return {{(SUM_W-I64_W){x[I64_W-1]}}, x};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cepm_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface cepm_in_if;
    logic                valid;
    logic                ready;
    cepm_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cepm_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface cepm_out_if;
    logic                 valid;
    logic                 ready;
    cepm_pkg::out_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cepm_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface cepm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [cepm_pkg::CFG_IDX_W-1:0]      index;
    logic [cepm_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cepm_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One weighted product: count times signed weight, exact, with int64 range flag
module cepm_lane (
    input  wire logic                                clk,
    input  wire logic [cepm_pkg::LANE_STG-1:0]       en,
    input  wire logic [cepm_pkg::COUNT_W-1:0]        count,
    input  wire logic [cepm_pkg::COEFF_W-1:0]        coeff,
    output cepm_pkg::lane_res_t                      res
);

    logic signed [cepm_pkg::PART_W-1:0] lo_next, hi_next;
    logic signed [cepm_pkg::PART_W-1:0] lo_reg, hi_reg;
    logic [cepm_pkg::PROD_W-1:0]        lo_ext, hi_ext, prod_full;
    cepm_pkg::lane_res_t                res_next, res_reg;

    // Stage 1: two half-width partial products
    assign lo_next = $signed({1'b0, count[cepm_pkg::HALF_W-1:0]}) * $signed(coeff);
    assign hi_next = $signed({1'b0, count[cepm_pkg::COUNT_W-1:cepm_pkg::HALF_W]})
                     * $signed(coeff);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    // Stage 2: recombine and check against the int64 range
    assign lo_ext = {{(cepm_pkg::PROD_W-cepm_pkg::PART_W){lo_reg[cepm_pkg::PART_W-1]}},
                     lo_reg};
    assign hi_ext = {{(cepm_pkg::PROD_W-cepm_pkg::PART_W){hi_reg[cepm_pkg::PART_W-1]}},
                     hi_reg};
    assign prod_full = (hi_ext << cepm_pkg::HALF_W) + lo_ext;

    always_comb
    begin
        res_next.prod = prod_full[cepm_pkg::I64_W-1:0];
        res_next.ovf  = !cepm_pkg::fits_i64_prod(prod_full);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ----- rtl/core/cepm_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Adds the lane products of both groups, checking every running sum
module cepm_merge (
    input  wire logic                                clk,
    input  wire logic [cepm_pkg::MERGE_STG-1:0]      en,
    input  wire cepm_pkg::lane_res_t                 eff_res  [cepm_pkg::GROUP_LANES],
    input  wire cepm_pkg::lane_res_t                 perf_res [cepm_pkg::GROUP_LANES],
    output logic [cepm_pkg::ACC_W-1:0]               acc,
    output logic                                     ovf
);

    cepm_pkg::lane_res_t        grp [2][cepm_pkg::GROUP_LANES];
    logic [cepm_pkg::SUM_W-1:0] a01_reg [2];
    logic [cepm_pkg::SUM_W-1:0] a23_reg [2];
    logic [cepm_pkg::SUM_W-1:0] p2_reg  [2];
    logic                       povf_reg [2];
    logic [cepm_pkg::I64_W-1:0] gsum_reg [2];
    logic                       govf_reg [2];
    logic [cepm_pkg::SUM_W-1:0] total;
    logic [cepm_pkg::ACC_W-1:0] acc_reg;
    logic                       ovf_reg;

    genvar g, l;
    generate
        for (l = 0; l < cepm_pkg::GROUP_LANES; l++)
        begin : g_map
            assign grp[0][l] = eff_res[l];
            assign grp[1][l] = perf_res[l];
        end

        for (g = 0; g < 2; g++)
        begin : g_grp
            logic [cepm_pkg::SUM_W-1:0] s2, s3;

            // Pair sums
            always_ff @(posedge clk)
            begin
                if (en[0])
                begin
                    a01_reg[g]  <= cepm_pkg::sext_sum(grp[g][0].prod)
                                   + cepm_pkg::sext_sum(grp[g][1].prod);
                    a23_reg[g]  <= cepm_pkg::sext_sum(grp[g][2].prod)
                                   + cepm_pkg::sext_sum(grp[g][3].prod);
                    p2_reg[g]   <= cepm_pkg::sext_sum(grp[g][2].prod);
                    povf_reg[g] <= grp[g][0].ovf | grp[g][1].ovf
                                   | grp[g][2].ovf | grp[g][3].ovf;
                end
            end

            // Running sums after lanes 2 and 3
            assign s2 = a01_reg[g] + p2_reg[g];
            assign s3 = a01_reg[g] + a23_reg[g];

            always_ff @(posedge clk)
            begin
                if (en[1])
                begin
                    gsum_reg[g] <= s3[cepm_pkg::I64_W-1:0];
                    govf_reg[g] <= povf_reg[g]
                                   | !cepm_pkg::fits_i64_sum(a01_reg[g])
                                   | !cepm_pkg::fits_i64_sum(s2)
                                   | !cepm_pkg::fits_i64_sum(s3);
                end
            end
        end
    endgenerate

    // Group total, clamp negative energy to zero
    assign total = cepm_pkg::sext_sum(gsum_reg[0]) + cepm_pkg::sext_sum(gsum_reg[1]);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            acc_reg <= total[cepm_pkg::SUM_W-1] ? '0 : total[cepm_pkg::ACC_W-1:0];
            ovf_reg <= govf_reg[0] | govf_reg[1] | !cepm_pkg::fits_i64_sum(total);
        end
    end

    assign acc = acc_reg;
    assign ovf = ovf_reg;

endmodule

`default_nettype wire

// ----- rtl/core/cepm_cdiv.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Pipelined division by a constant, several quotient bits per stage
module cepm_cdiv #(
    parameter int unsigned SCALE = cepm_pkg::COEFF_SCALE_DEF
) (
    input  wire logic                               clk,
    input  wire logic [cepm_pkg::CDIV_STG-1:0]      en,
    input  wire logic [cepm_pkg::ACC_W-1:0]         x,
    output logic [cepm_pkg::ACC_W-1:0]              q
);

    localparam int REM_W = $clog2(SCALE + 1);
    localparam logic [REM_W:0] SCALE_V = (REM_W + 1)'(SCALE);

    logic [cepm_pkg::CDIV_PAD-1:0] w_reg  [cepm_pkg::CDIV_STG];
    logic [REM_W-1:0]              r_reg  [cepm_pkg::CDIV_STG];
    logic [cepm_pkg::CDIV_PAD-1:0] w_next [cepm_pkg::CDIV_STG];
    logic [REM_W-1:0]              r_next [cepm_pkg::CDIV_STG];

    genvar s;
    generate
        for (s = 0; s < cepm_pkg::CDIV_STG; s++)
        begin : g_stg
            logic [cepm_pkg::CDIV_PAD-1:0] w_in;
            logic [REM_W-1:0]              r_in;

            if (s == 0)
            begin : g_first
                assign w_in = {{(cepm_pkg::CDIV_PAD-cepm_pkg::ACC_W){1'b0}}, x};
                assign r_in = '0;
            end
            else
            begin : g_rest
                assign w_in = w_reg[s-1];
                assign r_in = r_reg[s-1];
            end

            // Restoring steps: shift in dividend bit, subtract when it fits
            always_comb
            begin
                logic [cepm_pkg::CDIV_PAD-1:0] w;
                logic [REM_W-1:0]              r;
                logic [REM_W:0]                t;
                logic                          ge;
                w = w_in;
                r = r_in;
                for (int k = 0; k < cepm_pkg::CDIV_STEP; k++)
                begin
                    t  = {r, w[cepm_pkg::CDIV_PAD-1]};
                    ge = (t >= SCALE_V);
                    t  = ge ? (t - SCALE_V) : t;
                    r  = t[REM_W-1:0];
                    w  = {w[cepm_pkg::CDIV_PAD-2:0], ge};
                end
                w_next[s] = w;
                r_next[s] = r;
            end

            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    w_reg[s] <= w_next[s];
                    r_reg[s] <= r_next[s];
                end
            end
        end
    endgenerate

    assign q = w_reg[cepm_pkg::CDIV_STG-1][cepm_pkg::ACC_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/cepm_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Pipelined unsigned restoring divider, one quotient bit per stage
module cepm_div (
    input  wire logic                              clk,
    input  wire logic [cepm_pkg::DIV_STG-1:0]      en,
    input  wire logic [cepm_pkg::DIV_W-1:0]        num,
    input  wire logic [cepm_pkg::DIV_W-1:0]        den,
    output logic [cepm_pkg::DIV_W-1:0]             quo
);

    logic [cepm_pkg::DIV_W-1:0] rem_reg [cepm_pkg::DIV_STG];
    logic [cepm_pkg::DIV_W-1:0] w_reg   [cepm_pkg::DIV_STG];
    logic [cepm_pkg::DIV_W-1:0] d_reg   [cepm_pkg::DIV_STG];

    genvar s;
    generate
        for (s = 0; s < cepm_pkg::DIV_STG; s++)
        begin : g_stg
            logic [cepm_pkg::DIV_W-1:0] rem_in, w_in, d_in, rem_next, w_next;
            logic [cepm_pkg::DIV_W:0]   t, t_sub;
            logic                       ge;

            if (s == 0)
            begin : g_first
                assign rem_in = '0;
                assign w_in   = num;
                assign d_in   = den;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[s-1];
                assign w_in   = w_reg[s-1];
                assign d_in   = d_reg[s-1];
            end

            assign t        = {rem_in, w_in[cepm_pkg::DIV_W-1]};
            assign ge       = (t >= {1'b0, d_in});
            assign t_sub    = t - {1'b0, d_in};
            assign rem_next = ge ? t_sub[cepm_pkg::DIV_W-1:0] : t[cepm_pkg::DIV_W-1:0];
            assign w_next   = {w_in[cepm_pkg::DIV_W-2:0], ge};

            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    rem_reg[s] <= rem_next;
                    w_reg[s]   <= w_next;
                    d_reg[s]   <= d_in;
                end
            end
        end
    endgenerate

    assign quo = w_reg[cepm_pkg::DIV_STG-1];

endmodule

`default_nettype wire

// ----- rtl/core/counter_energy_power_model_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake      Payload
// in_item   in   valid/ready    eight counter deltas, start/now time, two CPU times
// result    out  valid/ready    status, est_energy, power_wall_mw, power_oncpu_mw
// cfg       in   valid/ready    index (4 bits), data (32-bit weight)
//
// The pipeline holds 2 lane product stages, 3 merge stages, 8 stages of the
// divide-by-scale unit, 1 scaling stage, 63 stages of the two power dividers,
// and the output register. One item per cycle is accepted when not stalled.
// Any empty stage lets the stages before it advance, so input stays open while
// a result waits. Reset clears the weights to zero and empties the pipeline.
module counter_energy_power_model_unit #(
    parameter int unsigned COEFF_SCALE = cepm_pkg::COEFF_SCALE_DEF,
    parameter int unsigned EFF_EVENTS  = cepm_pkg::EFF_EVENTS_DEF,
    parameter int unsigned PERF_EVENTS = cepm_pkg::PERF_EVENTS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cepm_in_if.sink     in_item,
    cepm_out_if.source  result,
    cepm_cfg_if.sink    cfg
);

    localparam int NS = cepm_pkg::NUM_STG;

    typedef struct packed {
        logic                         bad;
        logic                         nort;
        logic                         ovf;
        logic [cepm_pkg::DIV_W-1:0]   diff;
        logic [cepm_pkg::DIV_W-1:0]   cpu;
    } sb_t;

    typedef struct packed {
        cepm_pkg::status_e               status;
        logic [cepm_pkg::ENERGY_W-1:0]   energy;
        logic [cepm_pkg::DIV_W-1:0]      scaled;
        logic [cepm_pkg::DIV_W-1:0]      diff;
        logic [cepm_pkg::DIV_W-1:0]      cpu;
    } sc_t;

    typedef struct packed {
        cepm_pkg::status_e               status;
        logic [cepm_pkg::ENERGY_W-1:0]   energy;
    } tail_t;

    logic [cepm_pkg::COEFF_W-1:0]   coeff_reg [cepm_pkg::NUM_COEFF];
    logic [NS-1:0]                  v_reg, en, v_in;
    logic [cepm_pkg::COUNT_W-1:0]   eff_cnt  [cepm_pkg::GROUP_LANES];
    logic [cepm_pkg::COUNT_W-1:0]   perf_cnt [cepm_pkg::GROUP_LANES];
    cepm_pkg::lane_res_t            eff_res  [cepm_pkg::GROUP_LANES];
    cepm_pkg::lane_res_t            perf_res [cepm_pkg::GROUP_LANES];
    logic [cepm_pkg::ACC_W-1:0]     acc;
    logic                           merge_ovf;
    logic [cepm_pkg::ACC_W-1:0]     energy_q;
    sb_t                            sb_next [cepm_pkg::ST_SCALE];
    sb_t                            sb_reg  [cepm_pkg::ST_SCALE];
    sc_t                            sc_next, sc_reg;
    logic [2*cepm_pkg::DIV_W-1:0]   scaled_full;
    tail_t                          tail_reg [cepm_pkg::DIV_STG];
    logic [cepm_pkg::DIV_W-1:0]     quo_wall, quo_cpu;
    cepm_pkg::out_item_t            out_next, out_reg;

    // Weight registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cepm_pkg::NUM_COEFF; i++)
            begin
                coeff_reg[i] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            case (cepm_pkg::cfg_reg_e'(cfg.index))
                cepm_pkg::REG_COEFF_EFF_A:  coeff_reg[0] <= cfg.data;
                cepm_pkg::REG_COEFF_EFF_B:  coeff_reg[1] <= cfg.data;
                cepm_pkg::REG_COEFF_EFF_C:  coeff_reg[2] <= cfg.data;
                cepm_pkg::REG_COEFF_EFF_D:  coeff_reg[3] <= cfg.data;
                cepm_pkg::REG_COEFF_PERF_A: coeff_reg[4] <= cfg.data;
                cepm_pkg::REG_COEFF_PERF_B: coeff_reg[5] <= cfg.data;
                cepm_pkg::REG_COEFF_PERF_C: coeff_reg[6] <= cfg.data;
                cepm_pkg::REG_COEFF_PERF_D: coeff_reg[7] <= cfg.data;
                default: ;
            endcase
        end
    end

    // Stage valids; a stage loads when empty or when its item moves on
    genvar i;
    generate
        for (i = 0; i < NS - 1; i++)
        begin : g_en
            assign en[i] = !v_reg[i] || en[i+1];
        end
    endgenerate
    assign en[NS-1] = !v_reg[NS-1] || result.ready;
    assign v_in     = {v_reg[NS-2:0], in_item.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= (en & v_in) | (~en & v_reg);
        end
    end

    assign in_item.ready = en[0];

    // Lanes
    assign eff_cnt[0]  = in_item.data.eff_count_a;
    assign eff_cnt[1]  = in_item.data.eff_count_b;
    assign eff_cnt[2]  = in_item.data.eff_count_c;
    assign eff_cnt[3]  = in_item.data.eff_count_d;
    assign perf_cnt[0] = in_item.data.perf_count_a;
    assign perf_cnt[1] = in_item.data.perf_count_b;
    assign perf_cnt[2] = in_item.data.perf_count_c;
    assign perf_cnt[3] = in_item.data.perf_count_d;

    generate
        for (i = 0; i < cepm_pkg::GROUP_LANES; i++)
        begin : g_lane
            if (i < EFF_EVENTS)
            begin : g_eff
                cepm_lane u_eff (
                    .clk   (clk),
                    .en    (en[cepm_pkg::ST_MERGE0-1:0]),
                    .count (eff_cnt[i]),
                    .coeff (coeff_reg[i]),
                    .res   (eff_res[i])
                );
            end
            else
            begin : g_eff_off
                assign eff_res[i] = '0;
            end

            if (i < PERF_EVENTS)
            begin : g_perf
                cepm_lane u_perf (
                    .clk   (clk),
                    .en    (en[cepm_pkg::ST_MERGE0-1:0]),
                    .count (perf_cnt[i]),
                    .coeff (coeff_reg[cepm_pkg::GROUP_LANES+i]),
                    .res   (perf_res[i])
                );
            end
            else
            begin : g_perf_off
                assign perf_res[i] = '0;
            end
        end
    endgenerate

    cepm_merge u_merge (
        .clk      (clk),
        .en       (en[cepm_pkg::ST_CDIV0-1:cepm_pkg::ST_MERGE0]),
        .eff_res  (eff_res),
        .perf_res (perf_res),
        .acc      (acc),
        .ovf      (merge_ovf)
    );

    cepm_cdiv #(
        .SCALE (COEFF_SCALE)
    ) u_cdiv (
        .clk (clk),
        .en  (en[cepm_pkg::ST_SCALE-1:cepm_pkg::ST_CDIV0]),
        .x   (acc),
        .q   (energy_q)
    );

    // Time checks and side data, carried beside the lanes, merge and divide-by-scale unit
    always_comb
    begin
        sb_next[0].bad  = (in_item.data.start_time_ns == '0)
                          || (in_item.data.now_time_ns <= in_item.data.start_time_ns);
        sb_next[0].diff = in_item.data.now_time_ns - in_item.data.start_time_ns;
        sb_next[0].cpu  = {1'b0, in_item.data.eff_cpu_ns} + {1'b0, in_item.data.perf_cpu_ns};
        sb_next[0].nort = (sb_next[0].cpu == '0);
        sb_next[0].ovf  = 1'b0;
    end

    generate
        for (i = 1; i < cepm_pkg::ST_SCALE; i++)
        begin : g_sb
            always_comb
            begin
                sb_next[i] = sb_reg[i-1];
                if (i == cepm_pkg::ST_CDIV0)
                begin
                    sb_next[i].ovf = merge_ovf;
                end
            end
        end

        for (i = 0; i < cepm_pkg::ST_SCALE; i++)
        begin : g_sb_reg
            always_ff @(posedge clk)
            begin
                if (en[i])
                begin
                    sb_reg[i] <= sb_next[i];
                end
            end
        end
    endgenerate

    // Energy range check, status, energy times 1e6
    assign scaled_full = {{(cepm_pkg::DIV_W-cepm_pkg::ENERGY_W){1'b0}},
                          energy_q[cepm_pkg::ENERGY_W-1:0]}
                         * {{(cepm_pkg::DIV_W-cepm_pkg::MW_W){1'b0}}, cepm_pkg::UJ_TO_MW};

    always_comb
    begin
        sc_next.energy = energy_q[cepm_pkg::ENERGY_W-1:0];
        sc_next.scaled = scaled_full[cepm_pkg::DIV_W-1:0];
        sc_next.diff   = sb_reg[cepm_pkg::ST_SCALE-1].diff;
        sc_next.cpu    = sb_reg[cepm_pkg::ST_SCALE-1].cpu;
        if (sb_reg[cepm_pkg::ST_SCALE-1].bad)
        begin
            sc_next.status = cepm_pkg::ST_BAD_TIME;
        end
        else if (sb_reg[cepm_pkg::ST_SCALE-1].nort)
        begin
            sc_next.status = cepm_pkg::ST_NO_RUN;
        end
        else if (sb_reg[cepm_pkg::ST_SCALE-1].ovf || (energy_q > cepm_pkg::ENERGY_MAX))
        begin
            sc_next.status = cepm_pkg::ST_OVERFLOW;
        end
        else
        begin
            sc_next.status = cepm_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[cepm_pkg::ST_SCALE])
        begin
            sc_reg <= sc_next;
        end
    end

    // Power dividers
    cepm_div u_div_wall (
        .clk (clk),
        .en  (en[cepm_pkg::ST_OUT-1:cepm_pkg::ST_DIV0]),
        .num (sc_reg.scaled),
        .den (sc_reg.diff),
        .quo (quo_wall)
    );

    cepm_div u_div_cpu (
        .clk (clk),
        .en  (en[cepm_pkg::ST_OUT-1:cepm_pkg::ST_DIV0]),
        .num (sc_reg.scaled),
        .den (sc_reg.cpu),
        .quo (quo_cpu)
    );

    // Status and energy ride beside the dividers
    generate
        for (i = 0; i < cepm_pkg::DIV_STG; i++)
        begin : g_tail
            always_ff @(posedge clk)
            begin
                if (en[cepm_pkg::ST_DIV0+i])
                begin
                    if (i == 0)
                    begin
                        tail_reg[i] <= '{status: sc_reg.status, energy: sc_reg.energy};
                    end
                    else
                    begin
                        tail_reg[i] <= tail_reg[(i == 0) ? 0 : i-1];
                    end
                end
            end
        end
    endgenerate

    // Output register; values forced to zero on any error
    always_comb
    begin
        out_next.status = tail_reg[cepm_pkg::DIV_STG-1].status;
        if (tail_reg[cepm_pkg::DIV_STG-1].status == cepm_pkg::ST_OK)
        begin
            out_next.est_energy     = tail_reg[cepm_pkg::DIV_STG-1].energy;
            out_next.power_wall_mw  = quo_wall;
            out_next.power_oncpu_mw = quo_cpu;
        end
        else
        begin
            out_next.est_energy     = '0;
            out_next.power_wall_mw  = '0;
            out_next.power_oncpu_mw = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid = v_reg[NS-1];
    assign result.data  = out_reg;

    // Checks
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (in_item.valid && in_item.ready) |=> v_reg[0])
        else $error("accepted item did not enter first stage");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[0] |-> in_item.ready)
        else $error("input stalled with empty first stage");

    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.status != cepm_pkg::ST_OK)
        |-> (result.data.est_energy == '0 && result.data.power_wall_mw == '0
             && result.data.power_oncpu_mw == '0))
        else $error("nonzero values on error status");

    a_energy_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.status == cepm_pkg::ST_OK)
        |-> ({{(cepm_pkg::ACC_W-cepm_pkg::ENERGY_W){1'b0}}, result.data.est_energy}
             <= cepm_pkg::ENERGY_MAX))
        else $error("energy above limit with ok status");

endmodule

`default_nettype wire

// ----- bench/counter_energy_power_model_unit_test.sv -----
`timescale 1ns / 1ps

module counter_energy_power_model_unit_test;

    localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam int LIMIT_CYCLES = 400000;

    logic clk;
    logic rst_n;

    cepm_in_if  in_ch ();
    cepm_out_if out_ch ();
    cepm_cfg_if cfg_ch ();

    counter_energy_power_model_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_ch.sink),
        .result  (out_ch.source),
        .cfg     (cfg_ch.sink)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Weights as the block holds them
    logic signed [cepm_pkg::COEFF_W-1:0] weights [cepm_pkg::NUM_COEFF];

    cepm_pkg::in_item_t  pending_samples [$];
    cepm_pkg::out_item_t expected_results [$];
    int        mismatches;
    int        results_seen;
    int        sample_count;
    int        cycle_count;
    bit        quiet_mode;
    logic      in_busy;
    int        ok_count, ovf_count, norun_count, bad_count;

    // Signed product with 64-bit range check; 128 bits hold any 48x32 product
    function automatic bit weighted_term(input logic [cepm_pkg::COUNT_W-1:0] cnt,
                                         input logic signed [cepm_pkg::COEFF_W-1:0] w,
                                         output longint term);
        logic signed [127:0] p;
        begin
            p = $signed({80'd0, cnt}) * 128'(w);
            term = p[63:0];
            return (p >= -(128'sd1 <<< 63)) && (p <= 128'(I64_MAX));
        end
    endfunction

    function automatic bit add_in_range(input longint a, input longint b,
                                        output longint s);
        logic signed [65:0] t;
        begin
            t = 66'(a) + 66'(b);
            s = t[63:0];
            return (t >= -(66'sd1 <<< 63)) && (t <= 66'(I64_MAX));
        end
    endfunction

    // Expected estimate for one sample
    function automatic cepm_pkg::out_item_t estimate_energy(input cepm_pkg::in_item_t s);
        cepm_pkg::out_item_t r;
        logic [cepm_pkg::COUNT_W-1:0] cnts [8];
        longint diff, acc, term, energy, scaled;
        logic [63:0] cpu;
        bit ok;
        begin
            r = '0;
            r.status = cepm_pkg::ST_OK;
            diff = longint'({1'b0, s.now_time_ns}) - longint'({1'b0, s.start_time_ns});
            cpu = {2'b0, s.eff_cpu_ns} + {2'b0, s.perf_cpu_ns};
            cnts = '{s.eff_count_a, s.eff_count_b, s.eff_count_c, s.eff_count_d,
                     s.perf_count_a, s.perf_count_b, s.perf_count_c, s.perf_count_d};
            if (s.start_time_ns == '0 || diff <= 0)
            begin
                r.status = cepm_pkg::ST_BAD_TIME;
                return r;
            end
            if (cpu == 0)
            begin
                r.status = cepm_pkg::ST_NO_RUN;
                return r;
            end
            // Group sums checked per term, then the groups are added
            ok = 1'b1;
            acc = 0;
            begin
                longint grp [2];
                for (int g = 0; g < 2; g++)
                begin
                    grp[g] = 0;
                    for (int i = 0; i < 4; i++)
                    begin
                        if (ok && !weighted_term(cnts[g*4+i], weights[g*4+i], term))
                            ok = 1'b0;
                        if (ok && !add_in_range(grp[g], term, grp[g]))
                            ok = 1'b0;
                    end
                end
                if (ok && !add_in_range(grp[0], grp[1], acc))
                    ok = 1'b0;
            end
            if (!ok)
            begin
                r.status = cepm_pkg::ST_OVERFLOW;
                return r;
            end
            energy = acc / longint'(cepm_pkg::COEFF_SCALE_DEF);
            if (energy < 0)
                energy = 0;
            if (energy > I64_MAX / 1000000)
            begin
                r.status = cepm_pkg::ST_OVERFLOW;
                return r;
            end
            scaled = energy * 1000000;
            r.est_energy = energy[cepm_pkg::ENERGY_W-1:0];
            r.power_wall_mw = cepm_pkg::POWER_W'(scaled / diff);
            r.power_oncpu_mw = cepm_pkg::POWER_W'(64'(scaled) / cpu);
            return r;
        end
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Count value biased to extremes, small numbers or full range
    function automatic logic [cepm_pkg::COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return cepm_pkg::COUNT_W'($urandom_range(0, 100000));
            3: return cepm_pkg::COUNT_W'(rand64() >> $urandom_range(16, 63));
            default: return cepm_pkg::COUNT_W'(rand64());
        endcase
    endfunction

    function automatic cepm_pkg::in_item_t random_sample();
        cepm_pkg::in_item_t s;
        logic [62:0] span;
        begin
            s.eff_count_a = pick_count();
            s.eff_count_b = pick_count();
            s.eff_count_c = pick_count();
            s.eff_count_d = pick_count();
            s.perf_count_a = pick_count();
            s.perf_count_b = pick_count();
            s.perf_count_c = pick_count();
            s.perf_count_d = pick_count();
            s.start_time_ns = cepm_pkg::TIME_W'(rand64() >> $urandom_range(1, 62));
            span = 63'(rand64() >> $urandom_range(1, 63));
            s.now_time_ns = s.start_time_ns + span;
            s.eff_cpu_ns = cepm_pkg::CPU_W'(rand64() >> $urandom_range(2, 63));
            s.perf_cpu_ns = cepm_pkg::CPU_W'(rand64() >> $urandom_range(2, 63));
            // Some broken windows and idle CPUs
            case ($urandom_range(0, 19))
                0: s.start_time_ns = '0;
                1: s.now_time_ns = s.start_time_ns;
                2: s.now_time_ns = cepm_pkg::TIME_W'(rand64());
                3: begin s.eff_cpu_ns = '0; s.perf_cpu_ns = '0; end
                4: begin s.start_time_ns = 1; s.now_time_ns = '1; end
                default: ;
            endcase
            if (s.start_time_ns == '0 && $urandom_range(0, 1))
                s.start_time_ns = 1;
            return s;
        end
    endfunction

    // Write one register and mirror it; the caller drops valid after the last one
    task automatic write_weight(input cepm_pkg::cfg_reg_e idx,
                                input logic [cepm_pkg::COEFF_W-1:0] w);
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx;
            cfg_ch.data <= w;
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            weights[idx] = w;
        end
    endtask

    task automatic wait_drained();
        begin
            while (pending_samples.size() != 0 || expected_results.size() != 0 || in_busy)
                @(posedge clk);
            repeat (90) @(posedge clk);
        end
    endtask

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
            in_busy = 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_results.push_back(estimate_energy(in_ch.data));
                sample_count++;
                in_busy = 1'b0;
            end
            if (!in_busy && pending_samples.size() != 0 &&
                (quiet_mode || $urandom_range(0, 99) >= 14))
            begin
                in_ch.data <= pending_samples.pop_front();
                in_ch.valid <= 1'b1;
                in_busy = 1'b1;
            end
            else if (!in_busy)
                in_ch.valid <= 1'b0;
        end
    end

    // Monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                cepm_pkg::out_item_t want;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with none expected, actual %p", $time, out_ch.data);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_seen++;
                    case (want.status)
                        cepm_pkg::ST_OK: ok_count++;
                        cepm_pkg::ST_OVERFLOW: ovf_count++;
                        cepm_pkg::ST_NO_RUN: norun_count++;
                        default: bad_count++;
                    endcase
                    if (out_ch.data.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, out_ch.data.status);
                        mismatches++;
                    end
                    if (out_ch.data.est_energy !== want.est_energy)
                    begin
                        $display("%0t: est_energy expected %0d actual %0d",
                                 $time, want.est_energy, out_ch.data.est_energy);
                        mismatches++;
                    end
                    if (out_ch.data.power_wall_mw !== want.power_wall_mw)
                    begin
                        $display("%0t: power_wall_mw expected %0d actual %0d",
                                 $time, want.power_wall_mw, out_ch.data.power_wall_mw);
                        mismatches++;
                    end
                    if (out_ch.data.power_oncpu_mw !== want.power_oncpu_mw)
                    begin
                        $display("%0t: power_oncpu_mw expected %0d actual %0d",
                                 $time, want.power_oncpu_mw, out_ch.data.power_oncpu_mw);
                        mismatches++;
                    end
                end
            end
            out_ch.ready <= quiet_mode || ($urandom_range(0, 99) >= 14);
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        cepm_pkg::in_item_t s;
        logic [cepm_pkg::COEFF_W-1:0] wset [8];
        mismatches = 0;
        results_seen = 0;
        sample_count = 0;
        cycle_count = 0;
        quiet_mode = 1'b0;
        ok_count = 0; ovf_count = 0; norun_count = 0; bad_count = 0;
        for (int i = 0; i < cepm_pkg::NUM_COEFF; i++)
            weights[i] = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: weights at reset, then modest and extreme weights
        s = '0;
        s.start_time_ns = 1; s.now_time_ns = 1001; s.eff_cpu_ns = 500;
        pending_samples.push_back(s);
        wait_drained();
        for (int i = 0; i < cepm_pkg::NUM_COEFF; i++)
            write_weight(cepm_pkg::cfg_reg_e'(i), 32'(1000 * (i + 1)));
        cfg_ch.valid <= 1'b0;
        s = '0;
        s.eff_count_a = 1000; s.perf_count_d = 12345;
        s.start_time_ns = 1; s.now_time_ns = 1000000001;
        s.eff_cpu_ns = 3; s.perf_cpu_ns = 7;
        pending_samples.push_back(s);
        s.start_time_ns = 0;                          // invalid start
        pending_samples.push_back(s);
        s.start_time_ns = 50; s.now_time_ns = 50;     // empty window
        pending_samples.push_back(s);
        s.now_time_ns = 10;                           // negative window
        pending_samples.push_back(s);
        s.now_time_ns = '1; s.eff_cpu_ns = 0; s.perf_cpu_ns = 0;  // no run time
        pending_samples.push_back(s);
        s.eff_cpu_ns = '1; s.perf_cpu_ns = '1;
        s.eff_count_a = '1; s.eff_count_b = '1; s.eff_count_c = '1; s.eff_count_d = '1;
        s.perf_count_a = '1; s.perf_count_b = '1; s.perf_count_c = '1; s.perf_count_d = '1;
        pending_samples.push_back(s);
        wait_drained();
        // Extremes: most negative and max positive weights, alternating
        for (int i = 0; i < cepm_pkg::NUM_COEFF; i++)
            write_weight(cepm_pkg::cfg_reg_e'(i), (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000);
        cfg_ch.valid <= 1'b0;
        pending_samples.push_back(s);                 // product overflow
        s.eff_count_a = 48'h1_0000; s.eff_count_b = 48'h1_0000;
        s.eff_count_c = 0; s.eff_count_d = 0;
        s.perf_count_a = 0; s.perf_count_b = 0; s.perf_count_c = 0; s.perf_count_d = 0;
        pending_samples.push_back(s);                 // small negative, clamped
        s.eff_count_a = 0;
        s.eff_count_b = 48'hFFFF_FFFF;
        pending_samples.push_back(s);                 // large energy, times scale overflows
        s.eff_count_b = '1;
        pending_samples.push_back(s);                 // product overflow
        wait_drained();

        // Random phases with fresh weight sets
        for (int ph = 0; ph < 8; ph++)
        begin
            for (int i = 0; i < cepm_pkg::NUM_COEFF; i++)
            begin
                case ($urandom_range(0, 3))
                    0: wset[i] = $urandom;
                    1: wset[i] = 32'($signed($urandom_range(0, 20000)) - 10000);
                    2: wset[i] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    default: wset[i] = $urandom_range(0, 5000);
                endcase
                write_weight(cepm_pkg::cfg_reg_e'(i), wset[i]);
            end
            cfg_ch.valid <= 1'b0;
            quiet_mode = (ph == 3);
            for (int n = 0; n < 190; n++)
                pending_samples.push_back(random_sample());
            // Hold off until all results are in, midway through the phase
            if (ph == 5)
            begin
                wait_drained();
                for (int n = 0; n < 20; n++)
                    pending_samples.push_back(random_sample());
            end
            wait_drained();
        end
        quiet_mode = 1'b0;

        $display("covered %0d samples, %0d results: %0d ok, %0d overflow,",
                 sample_count, results_seen, ok_count, ovf_count);
        $display("  %0d no-run-time, %0d bad-time, over eleven weight settings",
                 norun_count, bad_count);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/cepm_pkg.sv
rtl/core/cepm_in_if.sv
rtl/core/cepm_out_if.sv
rtl/core/cepm_cfg_if.sv
rtl/core/cepm_lane.sv
rtl/core/cepm_merge.sv
rtl/core/cepm_cdiv.sv
rtl/core/cepm_div.sv
rtl/core/counter_energy_power_model_unit.sv
bench/counter_energy_power_model_unit_test.sv
